>>> hw/rtl/crc32c_pkg.sv
package crc32c_pkg;

    localparam int CRC_W          = 32;
    localparam int DATA_W         = 64;
    localparam int BYTE_W         = 8;
    localparam int WORD_BYTES     = DATA_W / BYTE_W;
    localparam int CNT_W          = 4;
    localparam int MAX_BYTES      = 16;
    localparam int BYTES_PER_WORD = 8;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]  t_count;

    // control that travels with a word from the lane stage to the merge stage
    typedef struct packed {
        t_count count;
        logic   first;
        logic   last;
    } t_stage_ctl;

    // fold one byte into the register, eight reflected shift/XOR steps
    function automatic t_crc fold_byte(input t_crc crc, input logic [BYTE_W-1:0] b);
        t_crc c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // advance the register over n zero bytes; used with constant arguments only
    function automatic t_crc zero_bytes(input t_crc crc, input int n);
        t_crc c;
        c = crc;
        for (int k = 0; k < MAX_BYTES; k++) begin
            if (k < n) begin
                c = fold_byte(c, '0);
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crc32c_lane.sv
// One byte position of the word: pick the byte that lands here once the
// valid bytes are right-aligned, and register its zero-init CRC contribution.
module crc32c_lane #(
    parameter int LANES = 8,
    parameter int LANE  = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  crc32c_pkg::t_data   i_data,
    input  crc32c_pkg::t_count  i_count,
    output crc32c_pkg::t_crc    o_contrib
);

    localparam int SHIFT = LANES - 1 - LANE;

    logic [crc32c_pkg::BYTE_W-1:0] lane_byte;
    crc32c_pkg::t_crc              n_contrib;
    crc32c_pkg::t_crc              r_contrib;

    // data byte i sits at position i + LANES - count; leading zeros add nothing
    always_comb begin
        lane_byte = '0;
        for (int i = 0; i < LANES; i++) begin
            if ((5'(i) + 5'(LANES)) == (5'(LANE) + 5'(i_count))) begin
                lane_byte = i_data[crc32c_pkg::BYTE_W*i +: crc32c_pkg::BYTE_W];
            end
        end
    end

    // fixed linear map: XOR of constant columns, one per set bit
    always_comb begin
        n_contrib = '0;
        for (int k = 0; k < crc32c_pkg::BYTE_W; k++) begin
            if (lane_byte[k]) begin
                n_contrib = n_contrib ^ crc32c_pkg::zero_bytes(
                    crc32c_pkg::fold_byte('0, 8'(1 << k)), SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_contrib <= n_contrib;
        end
    end

    assign o_contrib = r_contrib;

endmodule

>>> hw/rtl/crc32c_merge.sv
// Advance the running value, or all ones on a first word, over count bytes and XOR in all lane results.
module crc32c_merge #(
    parameter int LANES = 8
) (
    input  crc32c_pkg::t_crc        i_contrib [LANES],
    input  crc32c_pkg::t_stage_ctl  i_ctl,
    input  crc32c_pkg::t_crc        i_crc,
    output crc32c_pkg::t_crc        o_crc
);

    crc32c_pkg::t_crc base;
    crc32c_pkg::t_crc advanced;
    crc32c_pkg::t_crc lane_sum;

    assign base = i_ctl.first ? crc32c_pkg::CRC_ONES : i_crc;

    always_comb begin
        advanced = '0;
        for (int c = 0; c <= LANES; c++) begin
            if (i_ctl.count == crc32c_pkg::CNT_W'(c)) begin
                for (int m = 0; m < crc32c_pkg::CRC_W; m++) begin
                    if (base[m]) begin
                        advanced = advanced ^ crc32c_pkg::zero_bytes(
                            crc32c_pkg::t_crc'(1) << m, c);
                    end
                end
            end
        end
    end

    always_comb begin
        lane_sum = '0;
        for (int j = 0; j < LANES; j++) begin
            lane_sum = lane_sum ^ i_contrib[j];
        end
    end

    assign o_crc = advanced ^ lane_sum;

endmodule

>>> hw/rtl/crc32c_stream.sv
// CRC-32C stream checksum, reflected polynomial 0x82F63B78.
// A transferred word is registered in the stage-one byte lanes, then folded into
// the CRC register that drives the outputs; a stalled result channel can hold it.
// Throughput: one word per cycle unless the result channel stalls; only the update
// of the CRC register sits on the word-to-word path, the byte lanes a stage ahead.
// Reset (synchronous, active low): pipeline emptied, CRC register set to all ones.
module crc32c_stream #(
    parameter int BYTES_PER_WORD = crc32c_pkg::BYTES_PER_WORD
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [63:0]                i_data_word,
    input  logic [3:0]                 i_byte_count,
    input  logic                       i_first_word,
    input  logic                       i_last_word,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [31:0]                o_running_crc,
    output logic [31:0]                o_final_crc,
    output logic                       o_message_done
);

    // Lanes cover the bytes the data word can hold, capped by the parameter.
    localparam int LANES = (BYTES_PER_WORD < crc32c_pkg::WORD_BYTES)
                         ? BYTES_PER_WORD : crc32c_pkg::WORD_BYTES;

    crc32c_pkg::t_count      sat_count;
    crc32c_pkg::t_crc        lane_contrib [LANES];
    crc32c_pkg::t_crc        n_crc;
    crc32c_pkg::t_stage_ctl  r_s1_ctl;
    logic                    r_s1_valid;
    logic                    r_o_valid;
    logic                    r_done;
    crc32c_pkg::t_crc        r_crc;
    logic                    out_move;
    logic                    s1_ready;
    logic                    s1_load;

    // Saturate the byte count at the lane count; bytes above it are dropped.
    assign sat_count = (i_byte_count > crc32c_pkg::CNT_W'(LANES))
                     ? crc32c_pkg::CNT_W'(LANES) : i_byte_count;

    // Handshake: the output register advances when empty or taken; stage one
    // advances when empty or when it moves into the output register.
    assign out_move = !r_o_valid || !i_stall;
    assign s1_ready = !r_s1_valid || out_move;
    assign s1_load  = s1_ready && i_valid;
    assign o_stall  = !s1_ready;

    // Stage one: each lane computes the zero-init contribution of its byte.
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        crc32c_lane #(
            .LANES (LANES),
            .LANE  (j)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (s1_load),
            .i_data    (i_data_word),
            .i_count   (sat_count),
            .o_contrib (lane_contrib[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_ctl.count <= sat_count;
            r_s1_ctl.first <= i_first_word;
            r_s1_ctl.last  <= i_last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    // Stage two: fold the lane results into the running CRC.
    crc32c_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_contrib (lane_contrib),
        .i_ctl     (r_s1_ctl),
        .i_crc     (r_crc),
        .o_crc     (n_crc)
    );

    // The CRC register doubles as the output register: it changes only when
    // a word moves out of stage one, so a stalled result holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_crc     <= crc32c_pkg::CRC_ONES;
        end else if (out_move) begin
            r_o_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move && r_s1_valid) begin
            r_done <= r_s1_ctl.last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_running_crc  = r_crc;
    assign o_final_crc    = ~r_crc;
    assign o_message_done = r_done;

endmodule

>>> tb/sv/crc32c_stream_checker.sv
module crc32c_stream_checker #(
    parameter int BYTES_PER_WORD = crc32c_pkg::BYTES_PER_WORD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // word channel into the block
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  crc32c_pkg::t_data  i_data_word,
    input  crc32c_pkg::t_count i_byte_count,
    input  logic               i_first_word,
    input  logic               i_last_word,
    // result channel out of the block
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  crc32c_pkg::t_crc   i_running_crc,
    input  crc32c_pkg::t_crc   i_final_crc,
    input  logic               i_message_done,
    // verdict data for the top
    output int                 o_fail_count,
    output int                 o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        crc32c_pkg::t_crc running;
        crc32c_pkg::t_crc finished;
        logic             done;
    } t_crc_result;

    t_crc_result      expected_crcs[$];
    crc32c_pkg::t_crc model_crc = crc32c_pkg::CRC_ONES;

    // bit-serial CRC-32C, reflected: data bits enter LSB first
    function automatic crc32c_pkg::t_crc crc32c_fold_word(input crc32c_pkg::t_crc crc_in,
                                                          input crc32c_pkg::t_data data,
                                                          input crc32c_pkg::t_count count);
        crc32c_pkg::t_crc acc;
        int               n_bytes;
        logic             fb;
        n_bytes = count;
        if (n_bytes > BYTES_PER_WORD) n_bytes = BYTES_PER_WORD;
        if (n_bytes > crc32c_pkg::WORD_BYTES) n_bytes = crc32c_pkg::WORD_BYTES;
        acc = crc_in;
        for (int b = 0; b < crc32c_pkg::BYTE_W * n_bytes; b++) begin
            fb  = acc[0] ^ data[b];
            acc = acc >> 1;
            if (fb) acc = acc ^ crc32c_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_crc_result want;
        if (!i_rst_n) begin
            model_crc = crc32c_pkg::CRC_ONES;
            expected_crcs.delete();
        end else begin
            // results first, so a result never matches a word taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_crcs.size() == 0) begin
                    report_mismatch($sformatf("result %h/%h/%b with none expected",
                                              i_running_crc, i_final_crc, i_message_done));
                end else begin
                    want = expected_crcs.pop_front();
                    if (i_running_crc !== want.running)
                        report_mismatch($sformatf("running_crc %h, expected %h",
                                                  i_running_crc, want.running));
                    if (i_final_crc !== want.finished)
                        report_mismatch($sformatf("final_crc %h, expected %h",
                                                  i_final_crc, want.finished));
                    if (i_message_done !== want.done)
                        report_mismatch($sformatf("message_done %b, expected %b",
                                                  i_message_done, want.done));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_first_word) model_crc = crc32c_pkg::CRC_ONES;
                model_crc     = crc32c_fold_word(model_crc, i_data_word, i_byte_count);
                want.running  = model_crc;
                want.finished = ~model_crc;
                want.done     = i_last_word;
                expected_crcs.push_back(want);
            end
        end
        o_pending = expected_crcs.size();
    end

endmodule

>>> tb/sv/crc32c_stream_tb.sv
module crc32c_stream_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // no transfer on either channel for this many cycles means the block hung
    localparam int WATCHDOG_LIMIT = 3000;
    // margin after the last owed result, to catch stray results
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEMS_PER_PASS = 570;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    crc32c_pkg::t_data  i_data_word    = '0;
    crc32c_pkg::t_count i_byte_count   = '0;
    logic               i_first_word   = 1'b0;
    logic               i_last_word    = 1'b0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    crc32c_pkg::t_crc   o_running_crc;
    crc32c_pkg::t_crc   o_final_crc;
    logic               o_message_done;

    int mismatch_count;
    int pending_results;
    int snd_idle_pct = 7;
    int rcv_idle_pct = 70;
    int quiet_cycles = 0;
    int words_sent   = 0;

    always #6 i_clk = ~i_clk;

    crc32c_stream DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_first_word   (i_first_word),
        .i_last_word    (i_last_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_running_crc  (o_running_crc),
        .o_final_crc    (o_final_crc),
        .o_message_done (o_message_done)
    );

    // Predict and compare beside the block; it hands back the failure count
    // and the number of results still owed.
    crc32c_stream_checker crc_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_first_word   (i_first_word),
        .i_last_word    (i_last_word),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_running_crc  (o_running_crc),
        .i_final_crc    (o_final_crc),
        .i_message_done (o_message_done),
        .o_fail_count   (mismatch_count),
        .o_pending      (pending_results)
    );

    // Stall the result channel at random; the rate follows the current phase.
    always @(negedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // Count cycles without any transfer; give up once the limit is hit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word and hold it until the transfer. Enter and leave at a
    // falling edge; valid is raised without looking at stall.
    task automatic send_word(input crc32c_pkg::t_data data, input crc32c_pkg::t_count count,
                             input logic first, input logic last);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_word  <= data;
        i_byte_count <= count;
        i_first_word <= first;
        i_last_word  <= last;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    function automatic crc32c_pkg::t_data random_data();
        return {$urandom(), $urandom()};
    endfunction

    // Well-formed message: full words, then a last word of 1..8 bytes.
    task automatic send_message(input int n_words);
        for (int k = 0; k < n_words; k++) begin
            if (k == n_words - 1)
                send_word(random_data(), crc32c_pkg::t_count'($urandom_range(1, 8)),
                          k == 0, 1'b1);
            else
                send_word(random_data(), crc32c_pkg::t_count'(8), k == 0, 1'b0);
        end
    endtask

    // Mostly well-formed messages; the rest are loose words with any count
    // and any framing, which exercises saturation and missing starts.
    task automatic run_random(input int n_items);
        int target;
        int n_words;
        target = words_sent + n_items;
        while (words_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                n_words = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 16)
                                                      : $urandom_range(1, 6);
                send_message(n_words);
            end else begin
                send_word(random_data(), crc32c_pkg::t_count'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            // now and then starve the block completely
            if ($urandom_range(0, 99) < 3) drain_results();
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words. Start straight after reset without a first word:
        // the register already holds all ones.
        send_word(64'h0, crc32c_pkg::t_count'(8), 1'b0, 1'b1);
        // continue after a last word without reloading
        send_word(64'hFFFF_FFFF_FFFF_FFFF, crc32c_pkg::t_count'(8), 1'b0, 1'b1);
        // the standard check string "123456789" across two words
        send_word(64'h3837_3635_3433_3231, crc32c_pkg::t_count'(8), 1'b1, 1'b0);
        send_word(64'h0000_0000_0000_0039, crc32c_pkg::t_count'(1), 1'b0, 1'b1);
        // extremes of the data word
        send_word(64'hFFFF_FFFF_FFFF_FFFF, crc32c_pkg::t_count'(8), 1'b1, 1'b1);
        send_word(64'h0, crc32c_pkg::t_count'(8), 1'b1, 1'b1);
        // zero byte count, with and without a reload
        send_word(64'hDEAD_BEEF_0123_4567, crc32c_pkg::t_count'(0), 1'b0, 1'b0);
        send_word(64'hDEAD_BEEF_0123_4567, crc32c_pkg::t_count'(0), 1'b1, 1'b1);
        // counts beyond the word saturate at eight bytes
        send_word(64'hA5A5_5A5A_C3C3_3C3C, crc32c_pkg::t_count'(9), 1'b1, 1'b0);
        send_word(64'h8000_0000_0000_0001, crc32c_pkg::t_count'(15), 1'b0, 1'b1);
        // bytes above the count are ignored
        send_word(64'hFFFF_FFFF_FFFF_FF00, crc32c_pkg::t_count'(1), 1'b1, 1'b1);
        send_word(64'h1234_5678_9ABC_DEF0, crc32c_pkg::t_count'(3), 1'b1, 1'b0);
        // every legal count once, inside one message
        for (int c = 1; c <= 8; c++)
            send_word(random_data(), crc32c_pkg::t_count'(c), 1'b0, c == 8);
        // first and last at once, then a repeated first inside a message
        send_word(random_data(), crc32c_pkg::t_count'(5), 1'b1, 1'b1);
        send_word(random_data(), crc32c_pkg::t_count'(8), 1'b1, 1'b0);
        send_word(random_data(), crc32c_pkg::t_count'(8), 1'b1, 1'b1);

        // Sender nearly always busy, receiver stalls most of the time.
        drain_results();
        run_random(ITEMS_PER_PASS);
        drain_results();

        // Swap: sender idles a lot, receiver rarely stalls.
        snd_idle_pct = 70;
        rcv_idle_pct = 7;
        run_random(ITEMS_PER_PASS);
        drain_results();

        // Full rate on both sides.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(ITEMS_PER_PASS);

        // Stop sending and wait for the last results, then watch for strays.
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/crc32c_pkg.sv
hw/rtl/crc32c_lane.sv
hw/rtl/crc32c_merge.sv
hw/rtl/crc32c_stream.sv
tb/sv/crc32c_stream_checker.sv
tb/sv/crc32c_stream_tb.sv
